### src/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants for the timer pool: the command and result
// formats, the timer entry layout, and the controller states.
// ----------------------------------------------------------------------------
package tpm_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIDX_W     = $clog2(NUM_TIMERS);
    localparam int COUNT_W    = $clog2(NUM_TIMERS + 1);
    localparam int CMD_W      = 3;
    localparam int TASK_W     = 8;
    localparam int SECS_W     = 16;
    localparam int TPS_W      = 10;
    localparam int TICKS_W    = 26;
    localparam int STATUS_W   = 2;

    localparam logic [TPS_W-1:0] TPS_RESET = 10'd60;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ACTIVATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG      = 2'd3;

    typedef enum logic [1:0] {
        TS_AVAIL = 2'd0,
        TS_ALLOC = 2'd1,
        TS_RUN   = 2'd2
    } tstate_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [3:0]        timer_index;
        logic [TASK_W-1:0] owner_task;
        logic [SECS_W-1:0] duration_seconds;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status_code;
        logic [3:0]          result_timer;
        logic [TASK_W-1:0]   result_task;
        logic                expired;
        logic                last_result;
    } out_item_t;

    typedef struct packed {
        tstate_t            state;
        logic [TASK_W-1:0]  owner;
        logic [TICKS_W-1:0] remaining;
    } tmr_entry_t;

    typedef struct packed {
        logic              en;
        logic [TIDX_W-1:0] addr;
        tmr_entry_t        data;
    } ram_wr_t;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic [TIDX_W-1:0] timer;
    } stk_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD_RD,
        S_CMD_EX,
        S_TICK,
        S_TICK_END
    } fsm_t;

endpackage

### src/tpm_timer_ram.sv
// ----------------------------------------------------------------------------
// tpm_timer_ram
// Timer entry store: one write port, one read port, registered read data.
// Entries never written read back as an available, zeroed timer.
// ----------------------------------------------------------------------------
module tpm_timer_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpm_pkg::ram_wr_t            wr,
    input  logic                        rd_en,
    input  logic [tpm_pkg::TIDX_W-1:0]  rd_addr,
    output tpm_pkg::tmr_entry_t         rd_data
);
    import tpm_pkg::*;

    tmr_entry_t              mem_reg [NUM_TIMERS];
    tmr_entry_t              data_reg;
    logic                    data_vld_reg;
    logic [NUM_TIMERS-1:0]   vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
        end
    end

    // per-entry written flags stand in for clearing the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            data_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                data_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = data_vld_reg ? data_reg : tmr_entry_t'('0);

endmodule

### src/tpm_free_stack.sv
// ----------------------------------------------------------------------------
// tpm_free_stack
// LIFO of free timer indexes with fill count. Reset holds every timer,
// highest index on top.
// ----------------------------------------------------------------------------
module tpm_free_stack (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpm_pkg::stk_req_t           req,
    output logic [tpm_pkg::TIDX_W-1:0]  top_timer,
    output logic [tpm_pkg::COUNT_W-1:0] count
);
    import tpm_pkg::*;

    logic [TIDX_W-1:0]  stack_reg [NUM_TIMERS];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_m1;
    logic               do_pop;
    logic               do_push;

    assign count_m1 = count_reg - 1'b1;
    assign do_pop   = req.pop && (count_reg != '0);
    // push onto a full stack is dropped
    assign do_push  = req.push && (count_reg < COUNT_W'(NUM_TIMERS));

    always_comb
    begin
        count_next = count_reg;
        if (do_pop)
        begin
            count_next = count_m1;
        end
        else if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                stack_reg[i] <= TIDX_W'(i);
            end
            count_reg <= COUNT_W'(NUM_TIMERS);
        end
        else
        begin
            if (do_push && !do_pop)
            begin
                stack_reg[count_reg[TIDX_W-1:0]] <= req.timer;
            end
            count_reg <= count_next;
        end
    end

    assign top_timer = stack_reg[count_m1[TIDX_W-1:0]];
    assign count     = count_reg;

endmodule

### src/timer_pool_manager.sv
// Commands: an accepted command passes through S_CMD_RD and S_CMD_EX; its result
//   is registered as the block returns to idle, and busy covers both states.
// A tick walks the timer store one entry per cycle in S_TICK, then S_TICK_END
//   sends the last result; busy stays high for the whole walk.
// One result strobe per expiry (or one if none); the receiver cannot stall.
// Reset: all timers available, free stack full, ticks_per_second = 60.
// ----------------------------------------------------------------------------
// timer_pool_manager
// Pool of countdown timers with a free-timer stack. Commands allocate, free,
// activate and stop timers; a tick counts every running timer down and
// reports expiries in ascending index order.
// ----------------------------------------------------------------------------
module timer_pool_manager (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tpm_pkg::in_item_t          item,
    output logic                       result_strobe,
    output tpm_pkg::out_item_t         result,
    input  logic                       cfg_we,
    input  logic [tpm_pkg::TPS_W-1:0]  cfg_data
);
    import tpm_pkg::*;

    // controller state
    fsm_t                state_reg, state_next;

    // configuration
    logic [TPS_W-1:0]    tps_reg;

    // latched command
    logic [CMD_W-1:0]    cmd_reg;
    logic [TIDX_W-1:0]   idx_reg;
    logic [TASK_W-1:0]   task_reg;
    logic [TICKS_W-1:0]  prod_reg;
    logic [TICKS_W-1:0]  prod_next;

    // tick walk
    logic [TIDX_W-1:0]   scan_reg, scan_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [TIDX_W-1:0]   pend_timer_reg, pend_timer_next;
    logic [TASK_W-1:0]   pend_task_reg, pend_task_next;

    // result register
    out_item_t           res_reg, res_next;
    logic                strobe_reg, strobe_next;

    // store interfaces
    ram_wr_t             ram_wr;
    logic                rd_en;
    logic [TIDX_W-1:0]   rd_addr;
    tmr_entry_t          rd_data;
    stk_req_t            stk_req;
    logic [TIDX_W-1:0]   stk_top;
    logic [COUNT_W-1:0]  stk_count;

    logic                accept;
    logic                idx_ok;
    logic                scan_last;
    logic [TICKS_W-1:0]  dec_ticks;

    tpm_timer_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpm_free_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (stk_req),
        .top_timer (stk_top),
        .count     (stk_count)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign idx_ok    = ({1'b0, idx_reg} < (TIDX_W + 1)'(NUM_TIMERS));
    assign scan_last = (scan_reg == TIDX_W'(NUM_TIMERS - 1));
    // 16 x 10 product fits the 26-bit count exactly
    assign prod_next = TICKS_W'(item.duration_seconds) * TICKS_W'(tps_reg);
    assign dec_ticks = (rd_data.remaining != '0) ? rd_data.remaining - 1'b1 : '0;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (item.cmd == CMD_TICK) ? S_TICK : S_CMD_RD;
                end
            end
            S_CMD_RD:   state_next = S_CMD_EX;
            S_CMD_EX:   state_next = S_IDLE;
            S_TICK:
            begin
                if (scan_last)
                begin
                    state_next = S_TICK_END;
                end
            end
            S_TICK_END: state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath / outputs ----------------
    always_comb
    begin
        rd_en           = 1'b0;
        rd_addr         = '0;
        ram_wr          = ram_wr_t'('0);
        stk_req         = stk_req_t'('0);
        res_next        = res_reg;
        strobe_next     = 1'b0;
        scan_next       = scan_reg;
        pend_vld_next   = pend_vld_reg;
        pend_timer_next = pend_timer_reg;
        pend_task_next  = pend_task_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // tick starts its walk at entry 0 right away
                if (start && (item.cmd == CMD_TICK))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    scan_next     = '0;
                    pend_vld_next = 1'b0;
                end
            end

            S_CMD_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end

            S_CMD_EX:
            begin
                strobe_next          = 1'b1;
                res_next.status_code = ST_WRONG;
                res_next.result_timer = idx_reg;
                res_next.result_task = '0;
                res_next.expired     = 1'b0;
                res_next.last_result = 1'b1;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (stk_count == '0)
                        begin
                            res_next.status_code  = ST_NONE_FREE;
                            res_next.result_timer = '0;
                        end
                        else
                        begin
                            stk_req.pop               = 1'b1;
                            ram_wr.en                 = 1'b1;
                            ram_wr.addr               = stk_top;
                            ram_wr.data.state         = TS_ALLOC;
                            ram_wr.data.owner         = task_reg;
                            ram_wr.data.remaining     = '0;
                            res_next.status_code      = ST_OK;
                            res_next.result_timer     = stk_top;
                            res_next.result_task      = task_reg;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (idx_ok && (rd_data.state == TS_AVAIL))
                        begin
                            res_next.status_code = ST_ALREADY;
                        end
                        else if (idx_ok)
                        begin
                            ram_wr.en            = 1'b1;
                            ram_wr.addr          = idx_reg;
                            ram_wr.data          = tmr_entry_t'('0);
                            stk_req.push         = 1'b1;
                            stk_req.timer        = idx_reg;
                            res_next.status_code = ST_OK;
                        end
                    end
                    CMD_ACTIVATE:
                    begin
                        if (idx_ok && (rd_data.state == TS_ALLOC))
                        begin
                            ram_wr.en             = 1'b1;
                            ram_wr.addr           = idx_reg;
                            ram_wr.data.state     = TS_RUN;
                            ram_wr.data.owner     = rd_data.owner;
                            ram_wr.data.remaining = prod_reg;
                            res_next.status_code  = ST_OK;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (idx_ok && (rd_data.state == TS_RUN))
                        begin
                            ram_wr.en             = 1'b1;
                            ram_wr.addr           = idx_reg;
                            ram_wr.data.state     = TS_ALLOC;
                            ram_wr.data.owner     = rd_data.owner;
                            ram_wr.data.remaining = '0;
                            res_next.status_code  = ST_OK;
                        end
                    end
                    default:
                    begin
                        // unknown command: wrong-state status, index echoed
                    end
                endcase
            end

            S_TICK:
            begin
                // read runs one entry ahead of the write-back
                if (!scan_last)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                if (rd_data.state == TS_RUN)
                begin
                    ram_wr.en         = 1'b1;
                    ram_wr.addr       = scan_reg;
                    ram_wr.data.owner = rd_data.owner;
                    if (dec_ticks == '0)
                    begin
                        ram_wr.data.state     = TS_ALLOC;
                        ram_wr.data.remaining = '0;
                        // earlier expiry is not the last one: send it now
                        if (pend_vld_reg)
                        begin
                            strobe_next           = 1'b1;
                            res_next.status_code  = ST_OK;
                            res_next.result_timer = pend_timer_reg;
                            res_next.result_task  = pend_task_reg;
                            res_next.expired      = 1'b1;
                            res_next.last_result  = 1'b0;
                        end
                        pend_vld_next   = 1'b1;
                        pend_timer_next = scan_reg;
                        pend_task_next  = rd_data.owner;
                    end
                    else
                    begin
                        ram_wr.data.state     = TS_RUN;
                        ram_wr.data.remaining = dec_ticks;
                    end
                end
            end

            S_TICK_END:
            begin
                strobe_next           = 1'b1;
                res_next.status_code  = ST_OK;
                res_next.result_timer = pend_vld_reg ? pend_timer_reg : '0;
                res_next.result_task  = pend_vld_reg ? pend_task_reg : '0;
                res_next.expired      = pend_vld_reg;
                res_next.last_result  = 1'b1;
                pend_vld_next         = 1'b0;
            end

            default:
            begin
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tps_reg      <= TPS_RESET;
            strobe_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            scan_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            strobe_reg   <= strobe_next;
            pend_vld_reg <= pend_vld_next;
            scan_reg     <= scan_next;
            if (cfg_we)
            begin
                tps_reg <= cfg_data;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        pend_timer_reg <= pend_timer_next;
        pend_task_reg  <= pend_task_next;
        if (accept)
        begin
            cmd_reg  <= item.cmd;
            idx_reg  <= item.timer_index;
            task_reg <= item.owner_task;
            prod_reg <= prod_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

`ifndef SYNTH
    // an accepted transfer always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    // only the tick walk produces a non-final result
    a_nonlast_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last_result) |-> ($past(state_reg) == S_TICK))
        else $error("non-final result outside a tick walk");

    // expiries are always reported with ok status
    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.expired) |-> (result.status_code == ST_OK))
        else $error("expiry reported with error status");

    // no store write while idle
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_wr.en)
        else $error("timer store written while idle");

    // free count never exceeds the pool size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_count <= COUNT_W'(NUM_TIMERS))
        else $error("free count above pool size");
`endif

endmodule
